@@ src/lpfr_pkg.sv @@
`default_nettype none

package lpfr_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SIL_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY  = 1'b1;

  localparam logic [15:0] GAP_LIMIT_RST = 16'd2602;
  localparam logic [15:0] CRC_POLY_RST  = 16'h1021;

  // event codes
  localparam logic [2:0] EV_HEADER    = 3'd0;
  localparam logic [2:0] EV_DATA      = 3'd1;
  localparam logic [2:0] EV_GOOD      = 3'd2;
  localparam logic [2:0] EV_CRC_ERR   = 3'd3;
  localparam logic [2:0] EV_ACK       = 3'd4;
  localparam logic [2:0] EV_NAK       = 3'd5;
  localparam logic [2:0] EV_RESYNC    = 3'd6;
  localparam logic [2:0] EV_ZERO_LEN  = 3'd7;

  localparam logic [3:0] ACK_NIBBLE = 4'hA;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_DEST = 3'd1,
    PH_DATA = 3'd2,
    PH_CRC  = 3'd3,
    PH_ACK  = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] ev;
    logic [7:0] value;
    logic [7:0] dest;
    logic [7:0] len;
    logic [7:0] idx;
  } result_t;

endpackage

`default_nettype wire

@@ src/lpfr_crc_byte.sv @@
`default_nettype none

// MSB-first CRC16 update by one byte, eight shift steps.
module lpfr_crc_byte
  import lpfr_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  input  wire logic [15:0] poly,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

@@ src/lpfr_parser.sv @@
`default_nettype none

// Frame state and per-item decision. Result is combinational; state
// advances on step.
module lpfr_parser
  import lpfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire item_t       item,
  input  wire logic [15:0] gap_limit,
  input  wire logic [15:0] crc_poly,
  output result_t          res
);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        dest_r, dest_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              hi_ok_r, hi_ok_nxt;
  logic [SIL_W-1:0]  sil_r, sil_nxt;

  logic [15:0] crc_seed;
  logic [15:0] crc_upd;
  logic [7:0]  cnt_inc;
  logic        expired;
  logic        hi_match;
  logic        lo_match;

  assign crc_seed = (phase_r == PH_LEN) ? 16'h0000 : crc_r;

  lpfr_crc_byte u_crc (
    .crc_in  (crc_seed),
    .data_in (item.rx_byte),
    .poly    (crc_poly),
    .crc_out (crc_upd)
  );

  assign cnt_inc  = cnt_r + 8'd1;
  assign hi_match = (item.rx_byte == crc_r[15:8]);
  assign lo_match = (item.rx_byte == crc_r[7:0]);

  // silence counter saturates one above the gap limit
  always_comb begin
    sil_nxt = sil_r;
    if (item.kind) begin
      if (sil_r <= {1'b0, gap_limit}) begin
        sil_nxt = sil_r + {{(SIL_W-1){1'b0}}, 1'b1};
      end
    end else begin
      sil_nxt = '0;
    end
  end

  assign expired = (sil_nxt > {1'b0, gap_limit});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.kind) begin
      if (phase_r != PH_LEN && expired) begin
        phase_nxt = PH_LEN;
      end
    end else begin
      case (phase_r)
        PH_LEN:  if (item.rx_byte != 8'h00) phase_nxt = PH_DEST;
        PH_DEST: phase_nxt = PH_DATA;
        PH_DATA: if (cnt_inc >= len_r) phase_nxt = PH_CRC;
        PH_CRC: begin
          if (!hi_ok_r) begin
            if (!hi_match) phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = lo_match ? PH_ACK : PH_SKIP;
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase
    end
  end

  // frame registers and result
  always_comb begin
    len_nxt   = len_r;
    dest_nxt  = dest_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    hi_ok_nxt = hi_ok_r;
    res       = '0;
    res.dest  = dest_r;
    res.len   = len_r;
    if (item.kind) begin
      if (phase_r != PH_LEN && expired) begin
        len_nxt   = '0;
        dest_nxt  = '0;
        cnt_nxt   = '0;
        crc_nxt   = '0;
        hi_ok_nxt = 1'b0;
        res.vld   = (phase_r != PH_SKIP);
        res.ev    = EV_RESYNC;
      end
    end else begin
      case (phase_r)
        PH_LEN: begin
          if (item.rx_byte == 8'h00) begin
            res.vld  = 1'b1;
            res.ev   = EV_ZERO_LEN;
            res.dest = '0;
            res.len  = '0;
          end else begin
            len_nxt   = item.rx_byte;
            dest_nxt  = '0;
            cnt_nxt   = '0;
            crc_nxt   = crc_upd;
            hi_ok_nxt = 1'b0;
          end
        end
        PH_DEST: begin
          dest_nxt = item.rx_byte;
          crc_nxt  = crc_upd;
          res.vld  = 1'b1;
          res.ev   = EV_HEADER;
          res.dest = item.rx_byte;
        end
        PH_DATA: begin
          crc_nxt   = crc_upd;
          cnt_nxt   = cnt_inc;
          res.vld   = 1'b1;
          res.ev    = EV_DATA;
          res.value = item.rx_byte;
          res.idx   = cnt_r;
        end
        PH_CRC: begin
          if (!hi_ok_r) begin
            if (!hi_match) begin
              res.vld = 1'b1;
              res.ev  = EV_CRC_ERR;
            end else begin
              hi_ok_nxt = 1'b1;
            end
          end else begin
            res.vld = 1'b1;
            res.ev  = lo_match ? EV_GOOD : EV_CRC_ERR;
          end
        end
        PH_ACK: begin
          res.vld   = 1'b1;
          res.ev    = (item.rx_byte[3:0] == ACK_NIBBLE) ? EV_ACK : EV_NAK;
          res.value = item.rx_byte;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      len_r   <= '0;
      dest_r  <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
      hi_ok_r <= 1'b0;
      sil_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      dest_r  <= dest_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      hi_ok_r <= hi_ok_nxt;
      sil_r   <= sil_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/length_prefixed_crc16_frame_receiver.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_kind, in_rx_byte
// out       output     out_valid / out_ready  out_event_res, out_value, out_frame_dest,
//                                             out_frame_length, out_data_index
// cfg       input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// One item per cycle sustained while the output is not stalled. An item is held
// in the input register, the parser decides and updates frame state, and any
// result lands in the output register, which drives out_valid. Items that give
// no result still pass through the parser stage. A stalled output holds the
// parser stage; the input register then fills and in_ready drops.
// rst_n (sync, active low) clears valids, frame state and loads register defaults.
module length_prefixed_crc16_frame_receiver
  import lpfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input item
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_kind,
  input  wire logic [7:0]            in_rx_byte,
  // result item
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_event_res,
  output logic [7:0]                 out_value,
  output logic [7:0]                 out_frame_dest,
  output logic [7:0]                 out_frame_length,
  output logic [7:0]                 out_data_index,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // config registers
  logic [15:0] gap_limit_r;
  logic [15:0] crc_poly_r;

  // input stage
  logic        inq_valid_r, inq_valid_nxt;
  item_t       inq_r;

  // output stage
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r;

  result_t     res;
  logic        out_free;
  logic        step;
  logic        in_acc;

  // output slot frees when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  assign step     = inq_valid_r && out_free;
  assign in_ready = !inq_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RST;
      crc_poly_r  <= CRC_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAP_LIMIT: gap_limit_r <= cfg_wdata;
        CFG_CRC_POLY:  crc_poly_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lpfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (inq_r),
    .gap_limit (gap_limit_r),
    .crc_poly  (crc_poly_r),
    .res       (res)
  );

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_acc) begin
      inq_valid_nxt = 1'b1;
    end else if (step) begin
      inq_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = res.vld;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      inq_r.kind    <= in_kind;
      inq_r.rx_byte <= in_rx_byte;
    end
    if (step && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_r.ev;
  assign out_value        = out_r.value;
  assign out_frame_dest   = out_r.dest;
  assign out_frame_length = out_r.len;
  assign out_data_index   = out_r.idx;

endmodule

`default_nettype wire

@@ src/lpfr_checker.sv @@
`default_nettype none

module lpfr_checker
  import lpfr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_event_res,
  input wire logic [7:0] out_value,
  input wire logic [7:0] out_frame_dest,
  input wire logic [7:0] out_frame_length,
  input wire logic [7:0] out_data_index
);

  // held result keeps its event code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res))
    else $error("result changed while stalled");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ZERO_LEN |->
      out_value == 8'd0 && out_frame_dest == 8'd0 &&
      out_frame_length == 8'd0 && out_data_index == 8'd0)
    else $error("zero length event carries frame fields");

  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_HEADER |->
      out_frame_length != 8'd0 && out_value == 8'd0 && out_data_index == 8'd0)
    else $error("bad header event");

  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_DATA |-> out_data_index < out_frame_length)
    else $error("data index beyond declared length");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind length_prefixed_crc16_frame_receiver lpfr_checker u_lpfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_value        (out_value),
  .out_frame_dest   (out_frame_dest),
  .out_frame_length (out_frame_length),
  .out_data_index   (out_data_index)
);

`default_nettype wire
